### sv/slfl_pkg.sv
package slfl_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 9;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                      operation;
        logic signed [KEY_W-1:0]  key;
    } in_t;

    typedef struct packed
    {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
    } out_t;

    typedef struct packed
    {
        logic gt;
        logic eq;
    } cmp_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FREE,
        S_START,
        S_WALK,
        S_WR_NODE,
        S_WR_LINK,
        S_DONE
    } state_t;

endpackage

### sv/sorted_list_with_free_list_unit.sv
// Insert takes its node off the free list (via S_FREE) or from the fill counter,
// walks the list, then writes the node and its link; a delete that finds its key
// walks, writes the freed node onto the free list and relinks; a delete miss ends
// after the walk (at S_START on an empty list). The walk does one node-pool read
// per cycle. One operation at a time; a finished result waits in the output
// register while the next beat is taken. Reset empties both lists and the fill
// counter at once; pool contents are not cleared and need no sweep.
module sorted_list_with_free_list_unit #(
    parameter int POOL_NODES = 256
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  slfl_pkg::in_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output slfl_pkg::out_t rsp
);
    import slfl_pkg::*;

    localparam int IW = $clog2(POOL_NODES + 1);

    logic                    fin_valid;
    logic                    fin_ready;
    out_t                    fin;
    logic                    rd_en;
    logic [IW-1:0]           rd_idx;
    logic signed [KEY_W-1:0] rd_key;
    logic [IW-1:0]           rd_next;
    logic                    we;
    logic                    we_key;
    logic [IW-1:0]           wr_idx;
    logic signed [KEY_W-1:0] wr_key;
    logic [IW-1:0]           wr_next;
    cmp_t                    cmp;
    logic                    rsp_valid_reg;
    out_t                    rsp_reg;

    slfl_ctrl #(
        .POOL_NODES (POOL_NODES),
        .IW         (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .rd_next   (rd_next),
        .cmp       (cmp),
        .we        (we),
        .we_key    (we_key),
        .wr_idx    (wr_idx),
        .wr_key    (wr_key),
        .wr_next   (wr_next)
    );

    slfl_pool #(
        .POOL_NODES (POOL_NODES),
        .IW         (IW)
    ) u_pool (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_key  (rd_key),
        .rd_next (rd_next),
        .we      (we),
        .we_key  (we_key),
        .wr_idx  (wr_idx),
        .wr_key  (wr_key),
        .wr_next (wr_next)
    );

    slfl_cmp u_cmp (
        .node_key (rd_key),
        .key      (wr_key),
        .result   (cmp)
    );

    // output register: free, or being emptied this cycle
    assign fin_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            rsp_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            rsp_reg <= fin;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/slfl_cmp.sv
module slfl_cmp
(
    input  logic signed [slfl_pkg::KEY_W-1:0] node_key,
    input  logic signed [slfl_pkg::KEY_W-1:0] key,
    output slfl_pkg::cmp_t                    result
);
    import slfl_pkg::*;

    // signed compare of the node just read against the request key
    assign result.gt = (node_key > key);
    assign result.eq = (node_key == key);

endmodule

### sv/slfl_pool.sv
module slfl_pool #(
    parameter int POOL_NODES = 256,
    parameter int IW         = 9
)
(
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [IW-1:0]                     rd_idx,
    output logic signed [slfl_pkg::KEY_W-1:0] rd_key,
    output logic [IW-1:0]                     rd_next,
    input  logic                              we,
    input  logic                              we_key,
    input  logic [IW-1:0]                     wr_idx,
    input  logic signed [slfl_pkg::KEY_W-1:0] wr_key,
    input  logic [IW-1:0]                     wr_next
);
    import slfl_pkg::*;

    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    logic signed [KEY_W-1:0] key_mem [POOL_NODES];
    logic [IW-1:0]           next_mem [POOL_NODES];

    logic [IW-1:0] rd_off;
    logic [IW-1:0] wr_off;

    // nodes are numbered from 1
    assign rd_off = rd_idx - IW'(1);
    assign wr_off = wr_idx - IW'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            next_mem[wr_off[AW-1:0]] <= wr_next;
        end
        if (we && we_key)
        begin
            key_mem[wr_off[AW-1:0]] <= wr_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key  <= key_mem[rd_off[AW-1:0]];
            rd_next <= next_mem[rd_off[AW-1:0]];
        end
    end

endmodule

### sv/slfl_ctrl.sv
module slfl_ctrl #(
    parameter int POOL_NODES = 256,
    parameter int IW         = 9
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  slfl_pkg::in_t                     req,
    output logic                              fin_valid,
    input  logic                              fin_ready,
    output slfl_pkg::out_t                    fin,
    output logic                              rd_en,
    output logic [IW-1:0]                     rd_idx,
    input  logic [IW-1:0]                     rd_next,
    input  slfl_pkg::cmp_t                    cmp,
    output logic                              we,
    output logic                              we_key,
    output logic [IW-1:0]                     wr_idx,
    output logic signed [slfl_pkg::KEY_W-1:0] wr_key,
    output logic [IW-1:0]                     wr_next
);
    import slfl_pkg::*;

    localparam logic [IW-1:0] N_IDX = IW'(POOL_NODES);

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [IW-1:0]           fresh_reg, fresh_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [IW-1:0]           prev_reg, prev_next;
    logic [IW-1:0]           after_reg, after_next;
    logic [IW-1:0]           steps_reg, steps_next;
    logic [IW-1:0]           head_reg, head_next;
    logic [IW-1:0]           free_reg, free_next;
    logic [IW-1:0]           used_reg, used_next;
    status_t                 stat_reg, stat_next;
    logic [IW-1:0]           slot_reg, slot_next;
    logic [IW-1:0]           steps_inc;
    logic [IW+SLOT_W-1:0]    slot_ext;

    function automatic logic node_ok(input logic [IW-1:0] n);
        node_ok = (n != '0) && (n <= N_IDX);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            free_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        fresh_reg <= fresh_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        after_reg <= after_next;
        steps_reg <= steps_next;
        stat_reg  <= stat_next;
        slot_reg  <= slot_next;
    end

    assign steps_inc = steps_reg + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        fresh_next = fresh_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        after_next = after_reg;
        steps_next = steps_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        used_next  = used_reg;
        stat_next  = stat_reg;
        slot_next  = slot_reg;
        req_ready  = 1'b0;
        fin_valid  = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = cur_reg;
        we         = 1'b0;
        we_key     = 1'b0;
        wr_idx     = cur_reg;
        wr_next    = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next  = req.operation;
                    key_next = req.key;
                    if (req.operation == OP_DELETE)
                    begin
                        state_next = S_START;
                    end
                    else if (node_ok(free_reg))
                    begin
                        // pop the free list: its link comes back next cycle
                        fresh_next = free_reg;
                        rd_en      = 1'b1;
                        rd_idx     = free_reg;
                        state_next = S_FREE;
                    end
                    else if (used_reg < N_IDX)
                    begin
                        used_next  = used_reg + IW'(1);
                        fresh_next = used_reg + IW'(1);
                        state_next = S_START;
                    end
                    else
                    begin
                        stat_next  = STAT_FULL;
                        slot_next  = '0;
                        state_next = S_DONE;
                    end
                end
            end

            S_FREE:
            begin
                free_next  = rd_next;
                state_next = S_START;
            end

            S_START:
            begin
                prev_next  = '0;
                steps_next = '0;
                if (node_ok(head_reg))
                begin
                    rd_en      = 1'b1;
                    rd_idx     = head_reg;
                    cur_next   = head_reg;
                    state_next = S_WALK;
                end
                else if (op_reg == OP_INSERT)
                begin
                    cur_next   = '0;
                    state_next = S_WR_NODE;
                end
                else
                begin
                    stat_next  = STAT_MISS;
                    slot_next  = '0;
                    state_next = S_DONE;
                end
            end

            S_WALK:
            begin
                // node data for cur_reg is on the read port this cycle
                if (op_reg == OP_DELETE && cmp.eq)
                begin
                    after_next = rd_next;
                    state_next = S_WR_NODE;
                end
                else if (cmp.gt)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        state_next = S_WR_NODE;
                    end
                    else
                    begin
                        stat_next  = STAT_MISS;
                        slot_next  = '0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    steps_next = steps_inc;
                    cur_next   = node_ok(rd_next) ? rd_next : '0;
                    if (node_ok(rd_next) && steps_inc < N_IDX)
                    begin
                        rd_en  = 1'b1;
                        rd_idx = rd_next;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        state_next = S_WR_NODE;
                    end
                    else
                    begin
                        stat_next  = STAT_MISS;
                        slot_next  = '0;
                        state_next = S_DONE;
                    end
                end
            end

            S_WR_NODE:
            begin
                we = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    we_key  = 1'b1;
                    wr_idx  = fresh_reg;
                    wr_next = cur_reg;
                end
                else
                begin
                    // freed node goes on top of the free list
                    wr_idx    = cur_reg;
                    wr_next   = free_reg;
                    free_next = cur_reg;
                end
                state_next = S_WR_LINK;
            end

            S_WR_LINK:
            begin
                wr_idx  = prev_reg;
                wr_next = (op_reg == OP_INSERT) ? fresh_reg : after_reg;
                if (prev_reg == '0)
                begin
                    head_next = wr_next;
                end
                else
                begin
                    we = 1'b1;
                end
                stat_next  = STAT_DONE;
                slot_next  = (op_reg == OP_INSERT) ? fresh_reg : cur_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                fin_valid = 1'b1;
                if (fin_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign wr_key     = key_reg;
    assign slot_ext   = {{SLOT_W{1'b0}}, slot_reg};
    assign fin.status = stat_reg;
    assign fin.slot   = slot_ext[SLOT_W-1:0];

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= N_IDX)
        else $error("used count beyond pool size");

    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> node_ok(cur_reg) && steps_reg < N_IDX)
        else $error("walk on invalid node or past step limit");

    a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && stat_reg == STAT_FULL |->
            used_reg == N_IDX && free_reg == '0 && slot_reg == '0)
        else $error("full reported with nodes left");

    a_free_head_sane: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg == '0 || node_ok(free_reg))
        else $error("free list head out of range");

    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && stat_reg == STAT_DONE |-> node_ok(slot_reg))
        else $error("completed operation without a valid slot");

endmodule
